// ===== rtl/clb_pkg.sv =====
// types and codes shared by the compacting list buffer modules
// no dependencies
package clb_pkg;

  localparam int POS_W      = 4;
  localparam int DATA_W     = 32;
  localparam int FILL_W     = 5;
  localparam int SHOW_LIMIT = 16;

  typedef enum logic [2:0] {
    OP_SHOW   = 3'd0,
    OP_APPEND = 3'd1,
    OP_UPDATE = 3'd2,
    OP_DELETE = 3'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2,
    ST_BADOP  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHOW,
    S_DEL
  } ctrl_state_e;

  typedef struct packed {
    logic [2:0]              operation;
    logic [POS_W-1:0]        position;
    logic signed [DATA_W-1:0] new_value;
  } item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic                     entry_valid;
    logic [POS_W-1:0]         entry_index;
    logic signed [DATA_W-1:0] entry_value;
    logic [FILL_W-1:0]        fill_count;
    logic                     last_result;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic    append;
    logic    update;
    logic    show_start;
    logic    show_step;
    logic    del_start;
    logic    del_step;
    logic    dec;
    logic    emit;
    logic    entry;
    logic    last;
    status_e st;
  } clb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] op;
    logic       pos_ok;
    logic       del_shift;
    logic       full;
    logic       empty;
    logic       show_last;
    logic       del_last;
  } clb_status_t;

endpackage

// ===== rtl/clb_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module clb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/clb_ctrl.sv =====
// sequencer for the compacting list buffer: decodes a beat and steps show and delete
// depends on clb_pkg
module clb_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  clb_pkg::clb_status_t sts_i,
  output clb_pkg::clb_cmd_t    cmd_o
);

  import clb_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        accept;

  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (sts_i.op == OP_SHOW && !sts_i.empty) begin
            state_d = S_SHOW;
          end else if (sts_i.op == OP_DELETE && sts_i.pos_ok && sts_i.del_shift) begin
            state_d = S_DEL;
          end
        end
      end
      S_SHOW: begin
        if (sts_i.show_last) state_d = S_IDLE;
      end
      S_DEL: begin
        if (sts_i.del_last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    cmd_o.st   = ST_OK;
    cmd_o.last = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (sts_i.op)
            OP_SHOW: begin
              if (sts_i.empty) cmd_o.emit = 1'b1;
              else             cmd_o.show_start = 1'b1;
            end
            OP_APPEND: begin
              cmd_o.emit = 1'b1;
              if (sts_i.full) cmd_o.st = ST_FULL;
              else            cmd_o.append = 1'b1;
            end
            OP_UPDATE: begin
              cmd_o.emit = 1'b1;
              if (sts_i.pos_ok) cmd_o.update = 1'b1;
              else              cmd_o.st = ST_BADPOS;
            end
            OP_DELETE: begin
              if (!sts_i.pos_ok) begin
                cmd_o.emit = 1'b1;
                cmd_o.st   = ST_BADPOS;
              end else if (sts_i.del_shift) begin
                cmd_o.del_start = 1'b1;
              end else begin
                // last entry removed, nothing to move
                cmd_o.dec  = 1'b1;
                cmd_o.emit = 1'b1;
              end
            end
            default: begin
              cmd_o.emit = 1'b1;
              cmd_o.st   = ST_BADOP;
            end
          endcase
        end
      end
      S_SHOW: begin
        cmd_o.show_step = 1'b1;
        cmd_o.emit      = 1'b1;
        cmd_o.entry     = 1'b1;
        cmd_o.last      = sts_i.show_last;
      end
      S_DEL: begin
        cmd_o.del_step = 1'b1;
        if (sts_i.del_last) begin
          cmd_o.dec  = 1'b1;
          cmd_o.emit = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/clb_dp.sv =====
// datapath of the compacting list buffer: entry ram, fill count, pointer, result register
// depends on clb_pkg and clb_ram
module clb_dp #(
  parameter int CAPACITY = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  clb_pkg::item_t       item_i,
  input  clb_pkg::clb_cmd_t    cmd_i,
  output clb_pkg::clb_status_t sts_o,
  output logic                 res_valid_o,
  output clb_pkg::result_t     res_o
);

  import clb_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  logic [CW-1:0]     count_q, count_d;
  logic [AW-1:0]     ptr_q, ptr_d;
  logic              res_valid_q;
  result_t           res_q, res_d;

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [DATA_W-1:0] wdata, rdata;

  logic [PW-1:0]     pos_x, cnt_x;
  logic [CW:0]       ptr_1, ptr_2;

  assign pos_x = PW'(item_i.position);
  assign cnt_x = PW'(count_q);
  assign ptr_1 = (CW+1)'(ptr_q) + (CW+1)'(1);
  assign ptr_2 = (CW+1)'(ptr_q) + (CW+1)'(2);

  always_comb begin
    sts_o.op        = item_i.operation;
    sts_o.pos_ok    = pos_x < cnt_x;
    sts_o.del_shift = ((PW+1)'(pos_x) + (PW+1)'(1)) < (PW+1)'(cnt_x);
    sts_o.full      = (count_q == CW'(CAPACITY));
    sts_o.empty     = (count_q == '0);
    sts_o.show_last = (ptr_1 == (CW+1)'(count_q)) || (32'(ptr_q) == SHOW_LIMIT - 1);
    sts_o.del_last  = (ptr_2 == (CW+1)'(count_q));
  end

  // ram ports
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = item_i.new_value;
    raddr = '0;
    if (cmd_i.append) begin
      we    = 1'b1;
      waddr = AW'(count_q);
    end else if (cmd_i.update) begin
      we    = 1'b1;
      waddr = AW'(item_i.position);
    end else if (cmd_i.del_step) begin
      // move the entry above down by one place
      we    = 1'b1;
      waddr = ptr_q;
      wdata = rdata;
    end
    if (cmd_i.del_start)      raddr = AW'(PW'(item_i.position) + PW'(1));
    else if (cmd_i.show_step) raddr = AW'(ptr_1);
    else if (cmd_i.del_step)  raddr = AW'(ptr_2);
  end

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.show_start)                     ptr_d = '0;
    else if (cmd_i.del_start)                 ptr_d = AW'(item_i.position);
    else if (cmd_i.show_step || cmd_i.del_step) ptr_d = AW'(ptr_1);
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.append)   count_d = count_q + CW'(1);
    else if (cmd_i.dec) count_d = count_q - CW'(1);
  end

  always_comb begin
    res_d.status      = cmd_i.st;
    res_d.entry_valid = cmd_i.entry;
    res_d.entry_index = cmd_i.entry ? POS_W'(ptr_q) : '0;
    res_d.entry_value = cmd_i.entry ? rdata : '0;
    res_d.fill_count  = FILL_W'(count_d);
    res_d.last_result = cmd_i.last;
  end

  clb_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ptr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      res_valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/compacting_list_buffer_top.sv =====
// compacting list buffer: densely packed list of signed words with a fill count
// depends on clb_pkg, clb_ctrl, clb_dp, clb_ram
//
// a command beat (operation, position, new_value) is taken when start is high and
// busy is low. each result appears on res_o for one cycle with res_valid_o high;
// the receiver cannot hold results off and must take every one.
// append, update, unknown codes and delete of the last entry: one result, in the
// cycle after the beat, and busy stays low, so a new beat can follow every cycle.
// show: one result per stored entry (capped at 16), the first once the S_SHOW state
// has read it into the result register and then one per cycle; busy is high while
// entries are read out and drops as the last result appears. an empty list gives a
// single result in the cycle after the beat with busy staying low.
// delete below the last entry: the ram moves one entry per cycle through its one
// write port, so busy stays high for one S_DEL state per move, and the single
// result is registered in the last S_DEL state, together with the last move.
// reset empties the list at once (fill count zero); the entry ram is not cleared,
// entries at or above the fill count never reach a result.
module compacting_list_buffer_top #(
  parameter int CAPACITY = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  clb_pkg::item_t   item_i,
  output logic             res_valid_o,
  output clb_pkg::result_t res_o
);

  import clb_pkg::*;

  clb_cmd_t    cmd;
  clb_status_t sts;

  clb_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .sts_i (sts),
    .cmd_o (cmd)
  );

  clb_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

endmodule

// ===== dv/list_checker.sv =====
`timescale 1ns / 100ps
// checker for the compacting list buffer: watches command and result beats,
// keeps a shadow copy of the list and compares every result field by field
// depends on clb_pkg
module list_checker #(
  parameter int CAPACITY = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  clb_pkg::item_t   item_i,
  input  logic             res_valid_i,
  input  clb_pkg::result_t res_i,
  output int               fail_count_o,
  output int               pending_o
);

  import clb_pkg::*;

  logic signed [DATA_W-1:0] shadow_words [CAPACITY];
  int                       shadow_fill;
  result_t                  list_replies_q[$];
  int                       mismatches;

  // apply one command to the shadow list and queue the replies it must give
  function automatic void apply_list_op(input item_t it);
    result_t r;
    int      shown;
    r = '0;
    r.last_result = 1'b1;
    case (it.operation)
      OP_SHOW: begin
        shown = (shadow_fill > SHOW_LIMIT) ? SHOW_LIMIT : shadow_fill;
        if (shown == 0) begin
          r.status = ST_OK;
          r.fill_count = FILL_W'(shadow_fill);
          list_replies_q.push_back(r);
        end else begin
          for (int i = 0; i < shown; i++) begin
            r = '0;
            r.status      = ST_OK;
            r.entry_valid = 1'b1;
            r.entry_index = POS_W'(i);
            r.entry_value = shadow_words[i];
            r.fill_count  = FILL_W'(shadow_fill);
            r.last_result = (i == shown - 1);
            list_replies_q.push_back(r);
          end
        end
        return;
      end
      OP_APPEND: begin
        if (shadow_fill < CAPACITY) begin
          shadow_words[shadow_fill] = it.new_value;
          shadow_fill++;
          r.status = ST_OK;
        end else begin
          r.status = ST_FULL;
        end
      end
      OP_UPDATE: begin
        if (int'(it.position) < shadow_fill) begin
          shadow_words[it.position] = it.new_value;
          r.status = ST_OK;
        end else begin
          r.status = ST_BADPOS;
        end
      end
      OP_DELETE: begin
        if (int'(it.position) < shadow_fill) begin
          for (int i = int'(it.position); i + 1 < shadow_fill; i++)
            shadow_words[i] = shadow_words[i + 1];
          shadow_fill--;
          r.status = ST_OK;
        end else begin
          r.status = ST_BADPOS;
        end
      end
      default: r.status = ST_BADOP;
    endcase
    r.fill_count = FILL_W'(shadow_fill);
    list_replies_q.push_back(r);
  endfunction

  function automatic int field_differs(input string tag, input longint want,
                                       input longint got);
    if (want == got) return 0;
    $display("%0t: %s mismatch, expected %0d actual %0d", $time, tag, want, got);
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    int      bad;
    if (!rst_ni) begin
      shadow_fill = 0;
      list_replies_q.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // a result at this edge always belongs to an earlier beat
      if (res_valid_i) begin
        if (list_replies_q.size() == 0) begin
          $display("%0t: result with none outstanding, expected none actual %h",
                   $time, res_i);
          mismatches++;
        end else begin
          want = list_replies_q.pop_front();
          bad = 0;
          bad += field_differs("status", want.status, res_i.status);
          bad += field_differs("entry_valid", want.entry_valid, res_i.entry_valid);
          bad += field_differs("entry_index", want.entry_index, res_i.entry_index);
          bad += field_differs("entry_value", want.entry_value, res_i.entry_value);
          bad += field_differs("fill_count", want.fill_count, res_i.fill_count);
          bad += field_differs("last_result", want.last_result, res_i.last_result);
          if (bad != 0) mismatches++;
        end
      end
      if (start_i && !busy_i) apply_list_op(item_i);
      fail_count_o <= mismatches;
      pending_o    <= list_replies_q.size();
    end
  end

endmodule

// ===== dv/tb_compacting_list_buffer_top.sv =====
`timescale 1ns / 100ps
// testbench top for the compacting list buffer: directed and random command beats
// with sender idling phases; verdict from the list_checker failure and pending counts
// depends on clb_pkg, compacting_list_buffer_top, list_checker
module tb_compacting_list_buffer_top;
  import clb_pkg::*;

  localparam int CAPACITY = 16;
  localparam int RANDOM_PER_PHASE = 63;
  localparam int TAIL_CYCLES = 40;
  // codes with no meaning to the block
  localparam logic [2:0] OP_BAD_LO = 3'd4;
  localparam logic [2:0] OP_BAD_HI = 3'd7;

  logic    clk_i;
  logic    rst_ni;
  logic    start;
  logic    busy;
  item_t   item_i;
  logic    res_valid_o;
  result_t res_o;
  int      fail_count;
  int      pending;
  int      fill_est;
  int      idle_pct;

  compacting_list_buffer_top #(.CAPACITY(CAPACITY)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  list_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .item_i      (item_i),
    .res_valid_i (res_valid_o),
    .res_i       (res_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #1ms;
    $display("compacting_list_buffer_top regression: fail");
    $finish;
  end

  // hold the beat until taken, then maybe leave the sender idle for a while
  task automatic send_beat(input logic [2:0] op, input logic [POS_W-1:0] pos,
                           input logic signed [DATA_W-1:0] val);
    item_t it;
    it.operation = op;
    it.position  = pos;
    it.new_value = val;
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    if (op == OP_APPEND && fill_est < CAPACITY) fill_est++;
    if (op == OP_DELETE && int'(pos) < fill_est) fill_est--;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic random_beat();
    int          pick;
    logic [2:0]  op;
    logic [POS_W-1:0] pos;
    pick = $urandom_range(0, 99);
    // appends outweigh deletes; below three entries only appends and updates are drawn
    if (fill_est < 3) pick = pick / 2 + 10;
    if (pick < 10)      op = OP_SHOW;
    else if (pick < 48) op = OP_APPEND;
    else if (pick < 66) op = OP_UPDATE;
    else if (pick < 90) op = OP_DELETE;
    else                op = 3'($urandom_range(OP_BAD_LO, OP_BAD_HI));
    if (fill_est > 0 && $urandom_range(0, 99) < 80)
      pos = POS_W'($urandom_range(0, fill_est - 1));
    else
      pos = POS_W'($urandom_range(0, CAPACITY - 1));
    send_beat(op, pos, DATA_W'($urandom));
  endtask

  initial begin
    int phase_idle [4];
    phase_idle = '{0, 67, 28, 0};
    fill_est = 0;
    idle_pct = 0;
    rst_ni <= 1'b0;
    start  <= 1'b0;
    item_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list corner cases and unknown codes
    send_beat(OP_SHOW, '0, '0);
    send_beat(OP_UPDATE, '0, 32'sd5);
    send_beat(OP_DELETE, '1, 32'sd5);
    send_beat(OP_BAD_LO, '1, '1);
    send_beat(OP_BAD_HI, '0, '0);
    // fill to capacity, value extremes first; then one append too many, a show and an update
    send_beat(OP_APPEND, '0, 32'sh7fff_ffff);
    send_beat(OP_APPEND, '1, 32'sh8000_0000);
    send_beat(OP_APPEND, '0, '0);
    send_beat(OP_APPEND, '1, '1);
    while (fill_est < CAPACITY) send_beat(OP_APPEND, POS_W'($urandom), DATA_W'($urandom));
    send_beat(OP_APPEND, '0, 32'sd1);
    send_beat(OP_SHOW, '0, '0);
    send_beat(OP_UPDATE, '1, 32'sh8000_0000);
    // longest shift, then the last entry, then one in the middle
    send_beat(OP_DELETE, '0, '0);
    send_beat(OP_DELETE, POS_W'(fill_est - 1), '0);
    send_beat(OP_DELETE, POS_W'(fill_est / 2), '0);
    send_beat(OP_SHOW, '0, '0);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = phase_idle[ph];
      for (int n = 0; n < RANDOM_PER_PHASE; n++) random_beat();
    end

    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("compacting_list_buffer_top regression: pass");
    end else begin
      $display("compacting_list_buffer_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/clb_pkg.sv
rtl/clb_ram.sv
rtl/clb_ctrl.sv
rtl/clb_dp.sv
rtl/compacting_list_buffer_top.sv
dv/list_checker.sv
dv/tb_compacting_list_buffer_top.sv
